### rtl/assert_macros.svh
// Assertion macros shared by the table lookup RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### rtl/atlu_pkg.sv
// Types and constants for the associative table lookup/update block.
// No dependencies; imported by controller, datapath and top level.
`timescale 1ns / 1ps
package atlu_pkg;

  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CAP_BITS   = 5;
  localparam int CAP_RESET  = 16;

  typedef enum logic [2:0] {
    ST_NOT_FOUND = 3'd0,
    ST_FOUND     = 3'd1,
    ST_UPDATED   = 3'd2,
    ST_INSERTED  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    done;
    status_t code;
    logic    wr_en;
    logic    append;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic hit;
    logic miss;
    logic full;
  } sts_t;

endpackage

### rtl/atlu_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module atlu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/atlu_dpath.sv
// Datapath: request latch, key/value RAM, scan pointer, fill count, capacity
// and result registers. Depends on atlu_pkg, atlu_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module atlu_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_mode,
  input  logic [atlu_pkg::KEY_BITS-1:0]     in_key,
  input  logic [atlu_pkg::VALUE_BITS-1:0]   in_value_in,
  input  logic                              cfg_we,
  input  logic [atlu_pkg::CAP_BITS-1:0]     cfg_wdata,
  input  atlu_pkg::cmd_t                    cmd,
  output atlu_pkg::sts_t                    sts,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [atlu_pkg::VALUE_BITS-1:0]   out_value_out
);
  import atlu_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > CAP_BITS) ? FW : CAP_BITS;
  localparam int RW = KEY_BITS + VALUE_BITS;

  logic                  mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [CAP_BITS-1:0]   capacity_r;
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [FW-1:0]         issue_r, issue_nxt;
  logic [IW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                  cmp_valid_r, cmp_valid_nxt;
  logic                  out_valid_r;
  logic [2:0]            out_status_r;
  logic [VALUE_BITS-1:0] out_value_r;

  logic                  rd_en;
  logic [RW-1:0]         rdata;
  logic [IW-1:0]         waddr;
  logic                  hit;
  logic                  last;
  logic [CW-1:0]         cap_ext, depth_ext, usable;

  atlu_ram #(.WIDTH(RW), .DEPTH(DEPTH), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata ({key_r, value_r}),
    .re    (rd_en),
    .raddr (issue_r[IW-1:0]),
    .rdata (rdata)
  );

  assign rd_en = cmd.scan && (issue_r < fill_r);
  assign waddr = cmd.append ? fill_r[IW-1:0] : cmp_idx_r;
  assign hit   = cmp_valid_r && (rdata[RW-1:VALUE_BITS] == key_r);
  assign last  = cmp_valid_r ? ((FW'(cmp_idx_r) + 1'b1) == fill_r) : (fill_r == '0);

  assign cap_ext   = CW'(capacity_r);
  assign depth_ext = CW'(DEPTH);
  assign usable    = (cap_ext > depth_ext) ? depth_ext : cap_ext;

  always_comb begin
    sts.mode = mode_r;
    sts.hit  = hit;
    sts.miss = !hit && last;
    sts.full = CW'(fill_r) >= usable;
  end

  always_comb begin
    issue_nxt     = issue_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_valid_nxt = 1'b0;
    fill_nxt      = fill_r;
    if (cmd.load) begin
      issue_nxt = '0;
    end else if (rd_en) begin
      issue_nxt     = issue_r + 1'b1;
      cmp_idx_nxt   = issue_r[IW-1:0];
      cmp_valid_nxt = 1'b1;
    end
    if (cmd.wr_en && cmd.append) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      issue_r     <= '0;
      cmp_valid_r <= 1'b0;
      capacity_r  <= CAP_BITS'(CAP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      issue_r     <= issue_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= cmd.done;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    if (cmd.load) begin
      mode_r  <= in_mode;
      key_r   <= in_key;
      value_r <= in_value_in;
    end
    if (cmd.done) begin
      out_status_r <= cmd.code;
      out_value_r  <= (cmd.code == ST_FOUND) ? rdata[VALUE_BITS-1:0] : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;

  `ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_r > FW'(DEPTH), "fill count above depth")
  `ASSERT_HOLDS(a_fill_step, clk, rst_n, fill_r != $past(fill_r) |-> fill_r == $past(fill_r) + 1'b1, "fill count moved by other than one")
  `ASSERT_HOLDS(a_word_gap, clk, rst_n, out_valid_r |=> !out_valid_r, "result words on adjacent cycles")

endmodule

### rtl/atlu_ctrl.sv
// Controller FSM: sequences the linear key scan and decides the outcome.
// Depends on atlu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module atlu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  atlu_pkg::sts_t sts,
  output atlu_pkg::cmd_t cmd,
  output logic           busy
);
  import atlu_pkg::*;

  state_t state_r, state_nxt;
  logic   decide;

  assign decide = (state_r == S_SCAN) && (sts.hit || sts.miss);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.hit || sts.miss) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_NOT_FOUND;
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.scan   = (state_r == S_SCAN);
    cmd.done   = decide;
    if (decide) begin
      priority if (sts.hit) begin
        cmd.code  = sts.mode ? ST_UPDATED : ST_FOUND;
        cmd.wr_en = sts.mode;
      end else if (!sts.mode) begin
        cmd.code = ST_NOT_FOUND;
      end else if (sts.full) begin
        cmd.code = ST_FULL;
      end else begin
        cmd.code   = ST_INSERTED;
        cmd.wr_en  = 1'b1;
        cmd.append = 1'b1;
      end
    end
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_HOLDS(a_start_scan, clk, rst_n, (state_r == S_IDLE && start) |=> state_r == S_SCAN, "accepted word did not start a scan")
  `ASSERT_HOLDS(a_decide_idle, clk, rst_n, decide |=> state_r == S_IDLE, "scan did not end after decision")
  `ASSERT_NEVER(a_append_hit, clk, rst_n, cmd.append && sts.hit, "append on a matching key")

endmodule

### rtl/assoc_table_lookup_update.sv
// Top level of the associative table lookup/update block.
// Depends on atlu_pkg, atlu_ctrl, atlu_dpath (with atlu_ram).
`timescale 1ns / 1ps
// A request word is taken when start is high and busy is low. The table is
// searched from the oldest pair to the newest, one stored key per cycle
// through the single read port of the key/value RAM; busy stays high until a
// hit or the last stored key decides the outcome (at once on an empty table).
// The result word appears on out_status/out_value_out with out_valid for
// exactly one cycle right after busy drops; the receiver cannot stall it, and
// a new request may be started in that same cycle. Capacity must be written
// through cfg_we/cfg_wdata only while the block is idle; it is not enforced.
module assoc_table_lookup_update #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic [atlu_pkg::KEY_BITS-1:0]     in_key,
  input  logic [atlu_pkg::VALUE_BITS-1:0]   in_value_in,
  input  logic                              cfg_we,
  input  logic [atlu_pkg::CAP_BITS-1:0]     cfg_wdata,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [atlu_pkg::VALUE_BITS-1:0]   out_value_out
);
  import atlu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  atlu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  atlu_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_mode),
    .in_key        (in_key),
    .in_value_in   (in_value_in),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_value_out (out_value_out)
  );

endmodule
